>>> rtl/scrc_pkg.sv
`default_nettype none
package scrc_pkg;

  localparam int SCALE_LIMIT = 2048;
  localparam logic [31:0] RECIP_NUM = 32'h4000_0000;
  localparam int SHAPE_SHIFT = 7;

  localparam int DIV_BITS   = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  localparam int Y_W = 15;

  localparam int PIPE_LAST = DIV_STAGES + 1;

  localparam logic [9:0]  VIEW_HEIGHT_RST = 10'd160;
  localparam logic [11:0] LINE_PITCH_RST  = 12'd512;

  typedef enum logic {
    CFG_VIEW_HEIGHT = 1'b0,
    CFG_LINE_PITCH  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] screen_x;
    logic [10:0] scale;
    logic [8:0]  run_top;
    logic [8:0]  run_bottom;
    logic [15:0] run_shape;
  } in_item_t;

  typedef struct packed {
    logic [16:0] art_index;
    logic [31:0] step_fraction;
    logic [6:0]  step_integer;
    logic [21:0] screen_offset;
    logic [9:0]  line_count;
    logic [31:0] start_fraction;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [10:0] divisor;
  } div_ctl_t;

endpackage
`default_nettype wire

>>> rtl/scrc_stream_if.sv
`default_nettype none
interface scrc_in_if;
  logic               valid;
  logic               ready;
  scrc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scrc_out_if;
  logic                valid;
  logic                ready;
  scrc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/scrc_recip_div.sv
`default_nettype none
module scrc_recip_div (
  input  wire logic               clk_i,
  input  wire scrc_pkg::div_ctl_t ctl_i,
  output logic [31:0]             quo_o
);
  import scrc_pkg::*;

  logic [10:0] d_q [DIV_STAGES];
  logic [10:0] r_q [DIV_STAGES];
  logic [31:0] q_q [DIV_STAGES];
  logic [10:0] d_n [DIV_STAGES];
  logic [10:0] r_n [DIV_STAGES];
  logic [31:0] q_n [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [10:0] d_in;
    logic [10:0] r_in;
    logic [31:0] q_in;

    if (k == 0) begin : g_first
      assign d_in = ctl_i.divisor;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign d_in = d_q[k-1];
      assign r_in = r_q[k-1];
      assign q_in = q_q[k-1];
    end

    always_comb begin : p_step
      logic [10:0] d;
      logic [10:0] r;
      logic [31:0] q;
      logic [11:0] t;
      d = d_in;
      r = r_in;
      q = q_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {r, RECIP_NUM[DIV_BITS-1-(k*DIV_STEPS+j)]};
        if (t >= {1'b0, d}) begin
          r = 11'(t - {1'b0, d});
          q = {q[30:0], 1'b1};
        end else begin
          r = t[10:0];
          q = {q[30:0], 1'b0};
        end
      end
      d_n[k] = d;
      r_n[k] = r;
      q_n[k] = q;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        d_q[k] <= d_n[k];
        r_q[k] <= r_n[k];
        q_q[k] <= q_n[k];
      end
    end
  end

  assign quo_o = q_q[DIV_STAGES-1];
endmodule
`default_nettype wire

>>> rtl/sprite_column_run_clipper_core.sv
`default_nettype none
// Channel  Dir  Handshake        Payload
// in_i     in   valid / ready    screen_x, scale, run_top, run_bottom, run_shape
// out_o    out  valid / ready    art_index .. start_fraction (zero or one per run)
// cfg      in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// One run per cycle while the output is not stalled. A run passes the input register,
// the 8-stage reciprocal divider (4 quotient bits per stage) alongside the multiply
// and clip stages, then the reciprocal-scaling register and the output register.
// Reset clears valid bits and restores view_height 160, line_pitch 512.
// A stall at the output holds the whole pipeline; dropped runs leave bubbles.
module sprite_column_run_clipper_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  scrc_in_if.sink          in_i,
  scrc_out_if.source       out_o
);
  import scrc_pkg::*;

  typedef struct packed {
    logic [11:0] sx;
    logic [10:0] sc;
    logic [8:0]  top;
    logic [8:0]  bot;
    logic [15:0] shape;
    logic [19:0] p_top;
    logic [19:0] p_bot;
    logic        keep;
    logic        clipped;
    logic [10:0] negy1;
    logic [9:0]  y1c;
    logic [9:0]  count;
    logic [21:0] scr_off;
    logic [30:0] recip;
    logic [31:0] delta;
  } side_t;

  logic [9:0]  vh_q;
  logic [11:0] pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q    <= VIEW_HEIGHT_RST;
      pitch_q <= LINE_PITCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VIEW_HEIGHT: vh_q    <= cfg_data_i[9:0];
        CFG_LINE_PITCH:  pitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  side_t s_q [PIPE_LAST+1];
  side_t s_n [PIPE_LAST+1];
  logic  v_q [PIPE_LAST+1];

  div_ctl_t    div_ctl;
  logic [31:0] quo;

  assign div_ctl.en      = en;
  assign div_ctl.divisor = s_q[0].sc;

  scrc_recip_div u_div (
    .clk_i (clk_i),
    .ctl_i (div_ctl),
    .quo_o (quo)
  );

  logic signed [Y_W-1:0] y1, y2, y2c, cnt, vh_s;
  logic                  scale_ok;
  logic [41:0]           dprod;

  always_comb begin
    s_n[0]       = '0;
    s_n[0].sx    = in_i.data.screen_x;
    s_n[0].sc    = in_i.data.scale;
    s_n[0].top   = in_i.data.run_top;
    s_n[0].bot   = in_i.data.run_bottom;
    s_n[0].shape = in_i.data.run_shape;
    for (int k = 1; k <= PIPE_LAST; k++) begin
      s_n[k] = s_q[k-1];
    end

    s_n[1].p_top = s_q[0].sc * s_q[0].top;
    s_n[1].p_bot = s_q[0].sc * s_q[0].bot;

    vh_s = $signed({{(Y_W-10){1'b0}}, vh_q});
    y1 = $signed({2'b0, s_q[1].p_top[19:SHAPE_SHIFT]}) + $signed({6'b0, vh_q[9:1]})
         - $signed({4'b0, s_q[1].sc});
    y2 = $signed({2'b0, s_q[1].p_bot[19:SHAPE_SHIFT]}) + $signed({6'b0, vh_q[9:1]})
         - $signed({4'b0, s_q[1].sc});
    y2c = (y2 > vh_s) ? vh_s : y2;
    s_n[2].clipped = y1 < 0;
    s_n[2].negy1   = 11'(-y1);
    s_n[2].y1c     = (y1 < 0) ? 10'd0 : y1[9:0];
    cnt = y2c - ((y1 < 0) ? Y_W'(0) : y1);
    s_n[2].count   = cnt[9:0];
    scale_ok = (s_q[1].sc != 11'd0) && (int'(s_q[1].sc) < SCALE_LIMIT);
    s_n[2].keep = scale_ok && (y1 < vh_s) && (y2 > 0) && (cnt > 0);

    s_n[3].scr_off = 22'({11'b0, s_q[2].sx} + s_q[2].y1c * pitch_q);

    dprod = s_q[PIPE_LAST-1].negy1 * quo[30:0];
    s_n[PIPE_LAST].recip = quo[30:0];
    s_n[PIPE_LAST].delta = s_q[PIPE_LAST-1].clipped ? dprod[31:0] : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= PIPE_LAST; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_i.valid;
      for (int k = 1; k <= PIPE_LAST; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= PIPE_LAST; k++) s_q[k] <= s_n[k];
    end
  end

  logic      out_valid_q;
  out_item_t out_q;
  side_t     fin;
  assign fin = s_q[PIPE_LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[PIPE_LAST] && fin.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.art_index      <= 17'({1'b0, fin.shape} + fin.top[8:1] + fin.delta[31:24]);
      out_q.step_fraction  <= {fin.recip[23:0], 8'd0};
      out_q.step_integer   <= fin.recip[30:24];
      out_q.screen_offset  <= fin.scr_off;
      out_q.line_count     <= fin.count;
      out_q.start_fraction <= {fin.delta[23:0], 8'd0};
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_recip_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[PIPE_LAST] && fin.keep |->
      ({11'b0, fin.recip} * fin.sc <= {10'b0, RECIP_NUM})
      && (({11'b0, fin.recip} + 42'd1) * fin.sc > {10'b0, RECIP_NUM}))
    else $error("reciprocal misaligned with its run");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.line_count != 10'd0)
    else $error("draw command with zero lines");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(v_q[PIPE_LAST] && fin.keep))
    else $error("output valid without a kept run");

endmodule
`default_nettype wire
